/* hw/rtl/mstp_pkg.sv */
package mstp_pkg;

   // Configuration register width
   localparam int VCNT_W = 6;

   // Saturation ceiling of the running tree weight
   localparam logic [20:0] SUM_MAX = 21'h1FFFFF;

   // One edge transaction
   typedef struct packed {
      logic [4:0]  end_a;
      logic [4:0]  end_b;
      logic [15:0] edge_cost;
      logic        final_edge;
   } mstp_req_type;

   // One per-vertex result transaction
   typedef struct packed {
      logic [4:0]  node;
      logic [4:0]  tree_parent;
      logic        has_parent;
      logic [15:0] link_cost;
      logic [20:0] tree_cost;
      logic        connected;
      logic        run_end;
   } mstp_rsp_type;

   // Per-vertex part of a result, shifted down the cell row
   typedef struct packed {
      logic        has_parent;
      logic [4:0]  tree_parent;
      logic [15:0] link_cost;
   } node_res_type;

   // Broadcast command to the cell row
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_INIT,
      OP_PICK,
      OP_RELAX,
      OP_LOAD,
      OP_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        edge_go;
   } cell_ctrl_type;

endpackage

/* hw/rtl/mstp_cell.sv */
module mstp_cell import mstp_pkg::*; #(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16,
   parameter int ID           = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cell_ctrl_type                     ctrl,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] vc,
   input  logic [$clog2(MAX_VERTICES)-1:0]   sel_idx,
   input  logic [$clog2(MAX_VERTICES)-1:0]   edge_a,
   input  logic [$clog2(MAX_VERTICES)-1:0]   edge_b,
   input  logic [WEIGHT_BITS-1:0]            edge_w,
   input  logic                              cin_found,
   input  logic [WEIGHT_BITS:0]              cin_key,
   input  logic [$clog2(MAX_VERTICES)-1:0]   cin_idx,
   output logic                              cout_found,
   output logic [WEIGHT_BITS:0]              cout_key,
   output logic [$clog2(MAX_VERTICES)-1:0]   cout_idx,
   input  node_res_type                      sin,
   output node_res_type                      sout
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES+1);
   localparam int KW = WEIGHT_BITS + 1;
   localparam logic [KW-1:0] NO_EDGE = {1'b1, {WEIGHT_BITS{1'b0}}};
   localparam logic [IW-1:0] ME = IW'(ID);
   localparam logic [CW-1:0] ME_C = CW'(ID);

   // Row ID of the weight matrix
   logic [KW-1:0] row_mem [MAX_VERTICES];
   logic [KW-1:0] rdata_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [KW-1:0] wr_data;

   // Edge insert second stage and write forwarding
   logic                   pend_ff, pend_in;
   logic [IW-1:0]          pend_addr_ff, pend_addr_in;
   logic [WEIGHT_BITS-1:0] pend_w_ff;
   logic                   fwd_v_ff;
   logic [IW-1:0]          fwd_addr_ff;
   logic [KW-1:0]          fwd_data_ff;
   logic [KW-1:0]          old_w;
   logic                   upd;
   logic                   hit_a, hit_b;

   // Vertex state
   logic [KW-1:0] key_ff;
   logic          in_tree_ff;
   logic          known_ff;
   logic [IW-1:0] parent_ff;
   logic          active, cand, take_own, hp;
   node_res_type  res_ff;

   assign hit_a        = ctrl.edge_go && (edge_a == ME);
   assign hit_b        = ctrl.edge_go && (edge_b == ME);
   assign pend_in      = hit_a || hit_b;
   assign pend_addr_in = hit_a ? edge_b : edge_a;
   assign rd_addr      = (ctrl.op == OP_PICK) ? sel_idx : pend_addr_in;

   assign old_w = (fwd_v_ff && (fwd_addr_ff == pend_addr_ff)) ? fwd_data_ff : rdata_ff;
   assign upd   = pend_ff && ({1'b0, pend_w_ff} < old_w);

   assign wr_en   = (ctrl.op == OP_CLEAR) || upd;
   assign wr_addr = (ctrl.op == OP_CLEAR) ? sel_idx : pend_addr_ff;
   assign wr_data = (ctrl.op == OP_CLEAR) ? NO_EDGE : {1'b0, pend_w_ff};

   // Row memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= row_mem[rd_addr];
   end

   // Insert pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         fwd_v_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (ctrl.op == OP_CLEAR) begin
            fwd_v_ff <= 1'b0;
         end else if (upd) begin
            fwd_v_ff <= 1'b1;
         end
      end
      pend_addr_ff <= pend_addr_in;
      pend_w_ff    <= edge_w;
      if (upd) begin
         fwd_addr_ff <= pend_addr_ff;
         fwd_data_ff <= {1'b0, pend_w_ff};
      end
   end

   // Key, tree membership and parent
   always_ff @(posedge clock) begin
      if (reset) begin
         in_tree_ff <= 1'b0;
         known_ff   <= 1'b0;
      end else begin
         case (ctrl.op)
            OP_INIT: begin
               in_tree_ff <= 1'b0;
               known_ff   <= 1'b0;
            end
            OP_PICK: begin
               if (sel_idx == ME) begin
                  in_tree_ff <= 1'b1;
               end
            end
            OP_RELAX: begin
               if (!in_tree_ff && (rdata_ff < NO_EDGE) && (rdata_ff < key_ff)) begin
                  known_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (ctrl.op == OP_INIT) begin
         key_ff <= (ID == 0) ? '0 : NO_EDGE;
      end else if ((ctrl.op == OP_RELAX) && !in_tree_ff && (rdata_ff < NO_EDGE)
                   && (rdata_ff < key_ff)) begin
         key_ff    <= rdata_ff;
         parent_ff <= sel_idx;
      end
   end

   // Running minimum along the row; lower index wins ties
   assign active   = ME_C < vc;
   assign cand     = active && !in_tree_ff && (key_ff < NO_EDGE);
   assign take_own = cand && (!cin_found || (key_ff < cin_key));

   always_ff @(posedge clock) begin
      if (reset) begin
         cout_found <= 1'b0;
      end else begin
         cout_found <= take_own || cin_found;
      end
      cout_key <= take_own ? key_ff : cin_key;
      cout_idx <= take_own ? ME : cin_idx;
   end

   // Result shift line towards cell 0
   assign hp = known_ff && in_tree_ff;

   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_LOAD: begin
            res_ff.has_parent  <= hp;
            res_ff.tree_parent <= hp ? 5'(parent_ff) : 5'd0;
            res_ff.link_cost   <= hp ? 16'(key_ff) : 16'd0;
         end
         OP_SHIFT: begin
            res_ff <= sin;
         end
         default: begin
         end
      endcase
   end

   assign sout = res_ff;

endmodule

/* hw/rtl/minimum_spanning_tree_prim_core.sv */
// Prim minimum spanning tree over a row of vertex cells. Each cell holds one row of the
// weight matrix in a small memory plus its vertex key, parent and tree flag. Edges are
// taken one per cycle while loading. The final edge starts the run: a settle step for the
// last write, a step to seed the keys, then per round a scan while the minimum ripples down
// the cell row, a pick step that adds the picked vertex and a relax step for its
// neighbours, for up to vertex_count+1 rounds. Results then leave one per cycle unless
// the output stalls, vertex 0 first. After reset and after each run a clearing pass wipes
// the matrix; no edge is taken during a run or a clearing pass.
module minimum_spanning_tree_prim_core import mstp_pkg::*; #(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mstp_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mstp_rsp_type      rsp_data,
   input  logic              csr_we,
   input  logic [VCNT_W-1:0] csr_wdata
);

   localparam int IW   = $clog2(MAX_VERTICES);
   localparam int CW   = $clog2(MAX_VERTICES+1);
   localparam int KW   = WEIGHT_BITS + 1;
   localparam int CMPW = (CW > 5) ? CW : 5;
   localparam int VW   = (CW > VCNT_W) ? CW : VCNT_W;
   localparam int ADDW = (KW + 1 > 22) ? KW + 1 : 22;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_VERTICES - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_LAST,
      ST_INIT,
      ST_SCAN,
      ST_PICK,
      ST_RELAX,
      ST_FILL,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [VCNT_W-1:0] vc_ff;
   logic [CW-1:0]     vc_eff;
   logic [IW-1:0]     cnt_ff;
   logic [IW-1:0]     pick_ff;
   logic [CW-1:0]     picks_ff;
   logic [CW-1:0]     sent_ff;
   logic [20:0]       sum_ff;
   logic              rsp_valid_ff;
   mstp_rsp_type      rsp_data_ff;

   cell_ctrl_type     ctrl;
   logic [IW-1:0]     sel_idx;
   logic              accept, edge_ok, out_free, emit_go;
   logic [CMPW-1:0]   a_x, b_x, vc_x;
   logic [ADDW-1:0]   sum_add;
   logic [20:0]       sum_in;

   logic              c_found [MAX_VERTICES+1];
   logic [KW-1:0]     c_key   [MAX_VERTICES+1];
   logic [IW-1:0]     c_idx   [MAX_VERTICES+1];
   node_res_type      c_res   [MAX_VERTICES+1];

   // Vertex count in force
   always_comb begin
      if (vc_ff == '0) begin
         vc_eff = CW'(1);
      end else if (VW'(vc_ff) > VW'(MAX_VERTICES)) begin
         vc_eff = CW'(MAX_VERTICES);
      end else begin
         vc_eff = CW'(vc_ff);
      end
   end

   // Edge check
   assign a_x     = CMPW'(req_data.end_a);
   assign b_x     = CMPW'(req_data.end_b);
   assign vc_x    = CMPW'(vc_eff);
   assign edge_ok = (a_x != b_x) && (a_x < vc_x) && (b_x < vc_x);

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_go   = (state_ff == ST_EMIT) && out_free;

   // Saturating tree weight
   assign sum_add = ADDW'(sum_ff) + ADDW'(c_key[MAX_VERTICES]);
   assign sum_in  = (sum_add > ADDW'(SUM_MAX)) ? SUM_MAX : sum_add[20:0];

   // Command to the cell row
   always_comb begin
      ctrl.edge_go = accept && edge_ok;
      case (state_ff)
         ST_CLEAR: ctrl.op = OP_CLEAR;
         ST_INIT:  ctrl.op = OP_INIT;
         ST_PICK:  ctrl.op = c_found[MAX_VERTICES] ? OP_PICK : OP_IDLE;
         ST_RELAX: ctrl.op = OP_RELAX;
         ST_FILL:  ctrl.op = OP_LOAD;
         ST_EMIT:  ctrl.op = emit_go ? OP_SHIFT : OP_IDLE;
         default:  ctrl.op = OP_IDLE;
      endcase
      case (state_ff)
         ST_CLEAR: sel_idx = cnt_ff;
         ST_PICK:  sel_idx = c_idx[MAX_VERTICES];
         default:  sel_idx = pick_ff;
      endcase
   end

   // Cell row
   assign c_found[0]          = 1'b0;
   assign c_key[0]            = '0;
   assign c_idx[0]            = '0;
   assign c_res[MAX_VERTICES] = '0;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      mstp_cell #(
         .MAX_VERTICES (MAX_VERTICES),
         .WEIGHT_BITS  (WEIGHT_BITS),
         .ID           (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .vc         (vc_eff),
         .sel_idx    (sel_idx),
         .edge_a     (IW'(a_x)),
         .edge_b     (IW'(b_x)),
         .edge_w     (WEIGHT_BITS'(req_data.edge_cost)),
         .cin_found  (c_found[i]),
         .cin_key    (c_key[i]),
         .cin_idx    (c_idx[i]),
         .cout_found (c_found[i+1]),
         .cout_key   (c_key[i+1]),
         .cout_idx   (c_idx[i+1]),
         .sin        (c_res[i+1]),
         .sout       (c_res[i])
      );
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         vc_ff        <= VCNT_W'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            vc_ff <= csr_wdata;
         end
         if (out_free && !emit_go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               if (accept && req_data.final_edge) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: state_ff <= ST_INIT;
            ST_INIT: begin
               sum_ff   <= '0;
               picks_ff <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_PICK;
               end
            end
            ST_PICK: begin
               if (c_found[MAX_VERTICES]) begin
                  pick_ff  <= c_idx[MAX_VERTICES];
                  sum_ff   <= sum_in;
                  picks_ff <= picks_ff + 1'b1;
                  state_ff <= ST_RELAX;
               end else begin
                  state_ff <= ST_FILL;
               end
            end
            ST_RELAX: state_ff <= ST_SCAN;
            ST_FILL: begin
               sent_ff  <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.node        <= 5'(sent_ff);
                  rsp_data_ff.tree_parent <= c_res[0].tree_parent;
                  rsp_data_ff.has_parent  <= c_res[0].has_parent;
                  rsp_data_ff.link_cost   <= c_res[0].link_cost;
                  rsp_data_ff.tree_cost   <= sum_ff;
                  rsp_data_ff.connected   <= (picks_ff == vc_eff);
                  rsp_data_ff.run_end     <= (sent_ff == vc_eff - 1'b1);
                  sent_ff                 <= sent_ff + 1'b1;
                  if (sent_ff == vc_eff - 1'b1) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_CLEAR;
                  end
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Never more tree vertices than the vertex count while the tree grows
   a_picks_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) || (state_ff == ST_PICK) || (state_ff == ST_RELAX))
      |-> (picks_ff <= vc_eff))
      else $error("tree holds more vertices than the vertex count");

   // A vertex is never its own parent
   a_no_self_parent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.has_parent) |-> (rsp_data.tree_parent != rsp_data.node))
      else $error("vertex reported as its own parent");

   // On a connected graph every vertex but the root has a parent
   a_connected_parent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.connected && (rsp_data.node != 5'd0)) |-> rsp_data.has_parent)
      else $error("connected graph with a vertex lacking a parent");

   // Results leave one after another until the last one, stalls aside
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.run_end) |=> rsp_valid)
      else $error("result stream ended before the last vertex");
`endif

endmodule
